@@ src/i2c_master_register_read_macros.svh @@
// ----------------------------------------------------------------------------
// I2C register read master: assertion macros
// Clocked assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_READ_MACROS_SVH
`define I2C_MASTER_REGISTER_READ_MACROS_SVH

// checked only out of reset
`define I2CMRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define I2CMRR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/i2cmrr_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C register read master: package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package i2cmrr_pkg;

    localparam int          MAX_READ_BYTES_DEF = 16;
    localparam logic [6:0]  DEV_ADDR_RST       = 7'h36;
    localparam logic [15:0] PHASE_TICKS_RST    = 16'd500;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PROBE = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_DEV_ADDR    = 1'b0,
        CFG_PHASE_TICKS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WS_ADDR_WR = 2'd0,
        WS_REG     = 2'd1,
        WS_ADDR_RD = 2'd2
    } t_wstage;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_START0 = 5'd1,
        ST_START1 = 5'd2,
        ST_START2 = 5'd3,
        ST_WBIT0  = 5'd4,
        ST_WBIT1  = 5'd5,
        ST_WBIT2  = 5'd6,
        ST_WACK0  = 5'd7,
        ST_WACK1  = 5'd8,
        ST_WACK2  = 5'd9,
        ST_RBIT0  = 5'd10,
        ST_RBIT1  = 5'd11,
        ST_RACK0  = 5'd12,
        ST_RACK1  = 5'd13,
        ST_RACK2  = 5'd14,
        ST_STOP0  = 5'd15,
        ST_STOP1  = 5'd16,
        ST_STOP2  = 5'd17
    } t_step;

    // classified tick item
    typedef struct packed {
        logic       start;
        logic       probe;
        logic [6:0] addr;
        logic [7:0] regidx;
        logic [4:0] count;
        logic       sda;
    } t_cmd_item;

endpackage

@@ src/i2cmrr_front.sv @@
// ----------------------------------------------------------------------------
// I2C register read master: front end
// Holds the configuration registers and classifies each tick item.
// ----------------------------------------------------------------------------
module i2cmrr_front #(
    parameter int MAX_READ_BYTES = i2cmrr_pkg::MAX_READ_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    input  logic [1:0]             i_command,
    input  logic [7:0]             i_register_index,
    input  logic [4:0]             i_byte_count,
    input  logic [6:0]             i_probe_address,
    input  logic                   i_sda_level,
    output i2cmrr_pkg::t_cmd_item  o_item,
    output logic [15:0]            o_phase_ticks
);
    import i2cmrr_pkg::*;

    logic [6:0]  r_dev_addr;
    logic [15:0] r_phase_ticks;
    logic [4:0]  w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= DEV_ADDR_RST;
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEV_ADDR:    r_dev_addr    <= i_cfg_data[6:0];
                CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_count = i_byte_count;
        if (w_count == 5'd0) begin
            w_count = 5'd1;
        end
        if (32'(w_count) > MAX_READ_BYTES) begin
            w_count = 5'(MAX_READ_BYTES);
        end
    end

    always_comb begin
        o_item.start  = (t_cmd'(i_command) == CMD_READ) || (t_cmd'(i_command) == CMD_PROBE);
        o_item.probe  = (t_cmd'(i_command) == CMD_PROBE);
        o_item.addr   = o_item.probe ? i_probe_address : r_dev_addr;
        o_item.regidx = i_register_index;
        o_item.count  = w_count;
        o_item.sda    = i_sda_level;
    end

    assign o_phase_ticks = r_phase_ticks;

endmodule

@@ src/i2cmrr_queue.sv @@
// ----------------------------------------------------------------------------
// I2C register read master: item queue
// Two-entry FIFO between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cmrr_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  i2cmrr_pkg::t_cmd_item  i_item,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output i2cmrr_pkg::t_cmd_item  o_item
);
    import i2cmrr_pkg::*;

    t_cmd_item  r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ src/i2cmrr_back.sv @@
// ----------------------------------------------------------------------------
// I2C register read master: bus sequencer
// Advances the bus phase machine one tick per item and registers the result.
// ----------------------------------------------------------------------------
module i2cmrr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [15:0]            i_phase_ticks,
    input  logic                   i_q_valid,
    input  i2cmrr_pkg::t_cmd_item  i_q_item,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_scl_drive_low,
    output logic                   o_sda_drive_low,
    output logic                   o_byte_valid,
    output logic [7:0]             o_byte_value,
    output logic                   o_byte_last,
    output logic                   o_done_res,
    output logic [2:0]             o_ack_mask,
    output logic                   o_success,
    output logic                   o_busy_res
);
    import i2cmrr_pkg::*;

    t_step      r_step,  n_step,  s_step;
    logic [15:0] r_tick, n_tick,  s_tick;
    logic [3:0] r_bc,    n_bc,    s_bc;
    logic [7:0] r_shift, n_shift, s_shift;
    logic [4:0] r_rem,   n_rem,   s_rem;
    logic [2:0] r_ack,   n_ack,   s_ack;
    logic [7:0] r_reg,   n_reg,   s_reg;
    logic [6:0] r_addr,  n_addr,  s_addr;
    logic       r_probe, n_probe, s_probe;
    t_wstage    r_ws,    n_ws,    s_ws;

    logic       r_out_valid;
    logic       w_fire;
    logic [15:0] w_pt;
    logic       w_last;
    logic       w_scl, w_sda, w_bvalid, w_blast, w_done, w_succ, w_busy;
    logic [7:0] w_bvalue;

    assign w_fire      = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop     = w_fire;
    assign o_out_valid = r_out_valid;
    assign w_pt        = (i_phase_ticks == 16'd0) ? 16'd1 : i_phase_ticks;

    always_comb begin
        s_step  = r_step;
        s_tick  = r_tick;
        s_bc    = r_bc;
        s_shift = r_shift;
        s_rem   = r_rem;
        s_ack   = r_ack;
        s_reg   = r_reg;
        s_addr  = r_addr;
        s_probe = r_probe;
        s_ws    = r_ws;
        if (r_step == ST_IDLE && i_q_item.start) begin
            s_probe = i_q_item.probe;
            s_addr  = i_q_item.addr;
            s_reg   = i_q_item.regidx;
            s_rem   = i_q_item.count;
            s_ack   = 3'd0;
            s_ws    = WS_ADDR_WR;
            s_bc    = 4'd0;
            s_shift = 8'd0;
            s_tick  = 16'd0;
            s_step  = ST_START0;
        end

        n_step  = s_step;
        n_tick  = s_tick;
        n_bc    = s_bc;
        n_shift = s_shift;
        n_rem   = s_rem;
        n_ack   = s_ack;
        n_reg   = s_reg;
        n_addr  = s_addr;
        n_probe = s_probe;
        n_ws    = s_ws;

        w_scl    = 1'b0;
        w_sda    = 1'b0;
        w_bvalid = 1'b0;
        w_bvalue = 8'd0;
        w_blast  = 1'b0;
        w_done   = 1'b0;
        w_succ   = 1'b0;
        w_busy   = (s_step != ST_IDLE);
        w_last   = ({1'b0, s_tick} + 17'd1) >= {1'b0, w_pt};

        case (s_step)
            ST_START1: begin w_scl = 1'b0; w_sda = 1'b1; end
            ST_START2: begin w_scl = 1'b1; w_sda = 1'b1; end
            ST_WBIT0, ST_WBIT2: begin w_scl = 1'b1; w_sda = ~s_shift[7]; end
            ST_WBIT1:  begin w_scl = 1'b0; w_sda = ~s_shift[7]; end
            ST_WACK0, ST_WACK2, ST_RBIT1: begin w_scl = 1'b1; end
            ST_RACK0, ST_RACK2: begin w_scl = 1'b1; w_sda = (s_rem > 5'd1); end
            ST_RACK1:  begin w_scl = 1'b0; w_sda = (s_rem > 5'd1); end
            ST_STOP0:  begin w_scl = 1'b1; w_sda = 1'b1; end
            ST_STOP1:  begin w_scl = 1'b0; w_sda = 1'b1; end
            default: ;
        endcase

        if (w_busy) begin
            if (!w_last) begin
                n_tick = s_tick + 16'd1;
            end else begin
                n_tick = 16'd0;
                case (s_step)
                    ST_START0: n_step = ST_START1;
                    ST_START1: n_step = ST_START2;
                    ST_START2: begin
                        n_shift = {s_addr, (s_ws == WS_ADDR_RD)};
                        n_bc    = 4'd0;
                        n_step  = ST_WBIT0;
                    end
                    ST_WBIT0:  n_step = ST_WBIT1;
                    ST_WBIT1:  n_step = ST_WBIT2;
                    ST_WBIT2: begin
                        n_shift = {s_shift[6:0], 1'b0};
                        n_bc    = s_bc + 4'd1;
                        n_step  = (n_bc >= 4'd8) ? ST_WACK0 : ST_WBIT0;
                    end
                    ST_WACK0:  n_step = ST_WACK1;
                    ST_WACK1: begin
                        if (!i_q_item.sda) begin
                            case (s_ws)
                                WS_ADDR_WR: n_ack = s_ack | 3'b001;
                                WS_REG:     n_ack = s_ack | 3'b010;
                                default:    n_ack = s_ack | 3'b100;
                            endcase
                        end
                        n_step = ST_WACK2;
                    end
                    ST_WACK2: begin
                        n_bc = 4'd0;
                        if (s_ws == WS_ADDR_WR && s_probe) begin
                            n_step = ST_STOP0;
                        end else if (s_ws == WS_ADDR_WR) begin
                            n_ws    = WS_REG;
                            n_shift = s_reg;
                            n_step  = ST_WBIT0;
                        end else if (s_ws == WS_REG) begin
                            n_ws   = WS_ADDR_RD;
                            n_step = ST_START0;
                        end else begin
                            n_shift = 8'd0;
                            n_step  = ST_RBIT0;
                        end
                    end
                    ST_RBIT0: begin
                        n_shift = {s_shift[6:0], i_q_item.sda};
                        n_bc    = s_bc + 4'd1;
                        if (n_bc >= 4'd8) begin
                            w_bvalid = 1'b1;
                            w_bvalue = n_shift;
                            w_blast  = (s_rem <= 5'd1);
                        end
                        n_step = ST_RBIT1;
                    end
                    ST_RBIT1:  n_step = (s_bc >= 4'd8) ? ST_RACK0 : ST_RBIT0;
                    ST_RACK0:  n_step = ST_RACK1;
                    ST_RACK1:  n_step = ST_RACK2;
                    ST_RACK2: begin
                        if (s_rem > 5'd0) begin
                            n_rem = s_rem - 5'd1;
                        end
                        n_bc    = 4'd0;
                        n_shift = 8'd0;
                        n_step  = (n_rem == 5'd0) ? ST_STOP0 : ST_RBIT0;
                    end
                    ST_STOP0:  n_step = ST_STOP1;
                    ST_STOP1:  n_step = ST_STOP2;
                    ST_STOP2: begin
                        w_done = 1'b1;
                        w_succ = s_probe ? s_ack[0] : (s_ack == 3'b111);
                        n_step = ST_IDLE;
                    end
                    default:   n_step = ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_tick      <= 16'd0;
            r_bc        <= 4'd0;
            r_shift     <= 8'd0;
            r_rem       <= 5'd0;
            r_ack       <= 3'd0;
            r_reg       <= 8'd0;
            r_addr      <= 7'd0;
            r_probe     <= 1'b0;
            r_ws        <= WS_ADDR_WR;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_step  <= n_step;
                r_tick  <= n_tick;
                r_bc    <= n_bc;
                r_shift <= n_shift;
                r_rem   <= n_rem;
                r_ack   <= n_ack;
                r_reg   <= n_reg;
                r_addr  <= n_addr;
                r_probe <= n_probe;
                r_ws    <= n_ws;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_scl_drive_low <= w_scl;
            o_sda_drive_low <= w_sda;
            o_byte_valid    <= w_bvalid;
            o_byte_value    <= w_bvalue;
            o_byte_last     <= w_blast;
            o_done_res      <= w_done;
            o_ack_mask      <= n_ack;
            o_success       <= w_succ;
            o_busy_res      <= w_busy;
        end
    end

endmodule

@@ src/i2c_master_register_read.sv @@
// ----------------------------------------------------------------------------
// I2C register read master: top level
// Open-drain I2C sequencer for register reads and address probes.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  in      | i_in_valid / o_in_ready    | command, register, count, probe
//          |                            | address, sampled SDA
//  out     | o_out_valid / i_out_ready  | line drives, read byte, done, acks
//  cfg     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  One tick item in, one result out, one item per cycle while results are taken.
//  An accepted item is first written into the queue; when the sequencer
//  takes it, its result loads the output register.
//  The bus phase machine in the sequencer does one tick of work per item.
//  A two-entry queue lets the input side keep going while a result stalls.
//  Reset is synchronous, active low; it restores both configuration values.
// ----------------------------------------------------------------------------
module i2c_master_register_read #(
    parameter int MAX_READ_BYTES = i2cmrr_pkg::MAX_READ_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_register_index,
    input  logic [4:0]  i_byte_count,
    input  logic [6:0]  i_probe_address,
    input  logic        i_sda_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_drive_low,
    output logic        o_sda_drive_low,
    output logic        o_byte_valid,
    output logic [7:0]  o_byte_value,
    output logic        o_byte_last,
    output logic        o_done_res,
    output logic [2:0]  o_ack_mask,
    output logic        o_success,
    output logic        o_busy_res
);
    import i2cmrr_pkg::*;

    t_cmd_item   w_front_item;
    t_cmd_item   w_q_item;
    logic [15:0] w_phase_ticks;
    logic        w_q_full;
    logic        w_q_valid;
    logic        w_q_pop;

    assign o_in_ready = !w_q_full;

    i2cmrr_front #(
        .MAX_READ_BYTES (MAX_READ_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_register_index (i_register_index),
        .i_byte_count     (i_byte_count),
        .i_probe_address  (i_probe_address),
        .i_sda_level      (i_sda_level),
        .o_item           (w_front_item),
        .o_phase_ticks    (w_phase_ticks)
    );

    i2cmrr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    i2cmrr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_phase_ticks   (w_phase_ticks),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scl_drive_low (o_scl_drive_low),
        .o_sda_drive_low (o_sda_drive_low),
        .o_byte_valid    (o_byte_valid),
        .o_byte_value    (o_byte_value),
        .o_byte_last     (o_byte_last),
        .o_done_res      (o_done_res),
        .o_ack_mask      (o_ack_mask),
        .o_success       (o_success),
        .o_busy_res      (o_busy_res)
    );

endmodule

@@ src/i2cmrr_checker.sv @@
// ----------------------------------------------------------------------------
// I2C register read master: port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_register_read_macros.svh"

module i2cmrr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl_drive_low,
    input logic       o_sda_drive_low,
    input logic       o_byte_valid,
    input logic [7:0] o_byte_value,
    input logic       o_byte_last,
    input logic       o_done_res,
    input logic       o_success,
    input logic       o_busy_res
);

    `I2CMRR_ASSERT(a_success_done, o_out_valid && o_success |-> o_done_res, "success without done")
    `I2CMRR_ASSERT(a_byte_busy, o_out_valid && (o_byte_valid || o_done_res) |-> o_busy_res, "byte or done while idle")
    `I2CMRR_ASSERT(a_last_valid, o_out_valid && o_byte_last |-> o_byte_valid, "last flag without byte")
    `I2CMRR_ASSERT(a_idle_release, o_out_valid && !o_busy_res |-> !o_scl_drive_low && !o_sda_drive_low, "lines driven while idle")
    `I2CMRR_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_byte_value), "stalled result changed")

endmodule

bind i2c_master_register_read i2cmrr_checker u_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register read master: testbench
// Drives one bus tick item per handshake, with random sender gaps and
// receiver stalls, and checks every result against a cycle-exact model of
// the phase sequencer. A short table of directed ticks comes first, then
// random reads and probes under two address and phase-length settings.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cmrr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_PAD      = 4;
    localparam int N_DIR          = 15;
    localparam int N_SETTINGS     = 2;
    localparam int RAND_ITEMS     = 40;

    localparam logic [2:0] ACK_ADDR_WR = 3'b001;
    localparam logic [2:0] ACK_REG     = 3'b010;
    localparam logic [2:0] ACK_ADDR_RD = 3'b100;
    localparam logic [2:0] ACK_ALL     = 3'b111;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       byte_vld;
        logic [7:0] byte_val;
        logic       byte_end;
        logic       done;
        logic [2:0] acks;
        logic       ok;
        logic       busy;
    } t_bus_res;

    localparam t_bus_res RES_IDLE  = '0;
    localparam t_bus_res RES_START = '{scl_low: 1'b0, sda_low: 1'b0, byte_vld: 1'b0,
                                       byte_val: 8'h00, byte_end: 1'b0, done: 1'b0,
                                       acks: 3'd0, ok: 1'b0, busy: 1'b1};

    typedef struct packed {
        logic        is_cfg;
        t_cfg_idx    idx;
        logic [15:0] data;
        t_cmd        cmd;
        logic [7:0]  ridx;
        logic [4:0]  cnt;
        logic [6:0]  paddr;
        logic        sda;
        logic        sda_rand;
        logic [15:0] reps;
        logic        typed;
        t_bus_res    want;
    } t_dir_row;

    // cfg idx data | cmd reg cnt paddr | sda rand reps | typed want
    localparam t_dir_row DIRECTED [N_DIR] = '{
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_NONE,  8'h00, 5'd0,  7'h00,
          1'b0, 1'b0, 16'd1,     1'b1, RES_IDLE},
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_NONE,  8'hff, 5'd31, 7'h7f,
          1'b1, 1'b0, 16'd1,     1'b1, RES_IDLE},
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_RSVD,  8'hff, 5'd31, 7'h7f,
          1'b1, 1'b0, 16'd1,     1'b1, RES_IDLE},
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_RSVD,  8'h00, 5'd0,  7'h00,
          1'b0, 1'b0, 16'd1,     1'b1, RES_IDLE},
        // one-tick phases keep transfers short
        '{1'b1, CFG_PHASE_TICKS, 16'h0001, CMD_NONE, 8'h00, 5'd0, 7'h00,
          1'b0, 1'b0, 16'd0,     1'b0, RES_IDLE},
        // probe, all acked
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_PROBE, 8'h00, 5'd0,  7'h2a,
          1'b0, 1'b0, 16'd1,     1'b1, RES_START},
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_NONE,  8'h00, 5'd0,  7'h00,
          1'b0, 1'b0, 16'd34,    1'b0, RES_IDLE},
        '{1'b1, CFG_DEV_ADDR,    16'h007f, CMD_NONE, 8'h00, 5'd0, 7'h00,
          1'b0, 1'b0, 16'd0,     1'b0, RES_IDLE},
        // zero phase length behaves as one tick
        '{1'b1, CFG_PHASE_TICKS, 16'h0000, CMD_NONE, 8'h00, 5'd0, 7'h00,
          1'b0, 1'b0, 16'd0,     1'b0, RES_IDLE},
        // probe nobody answers
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_PROBE, 8'hff, 5'd31, 7'h7f,
          1'b1, 1'b0, 16'd1,     1'b1, RES_START},
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_NONE,  8'h00, 5'd0,  7'h00,
          1'b1, 1'b0, 16'd34,    1'b0, RES_IDLE},
        // oversized count clamps, every ack missing
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_READ,  8'hff, 5'd31, 7'h00,
          1'b1, 1'b0, 16'd1,     1'b0, RES_IDLE},
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_PROBE, 8'h00, 5'd0,  7'h00,
          1'b1, 1'b0, 16'd1,     1'b0, RES_IDLE},
        '{1'b0, CFG_DEV_ADDR, 16'h0000, CMD_NONE,  8'h00, 5'd0,  7'h00,
          1'b1, 1'b0, 16'd395,   1'b0, RES_IDLE},
        '{1'b1, CFG_DEV_ADDR,    16'h0000, CMD_NONE, 8'h00, 5'd0, 7'h00,
          1'b0, 1'b0, 16'd0,     1'b0, RES_IDLE}
    };

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    t_cfg_idx    i_cfg_index      = CFG_DEV_ADDR;
    logic [15:0] i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    t_cmd        i_command        = CMD_NONE;
    logic [7:0]  i_register_index = '0;
    logic [4:0]  i_byte_count     = '0;
    logic [6:0]  i_probe_address  = '0;
    logic        i_sda_level      = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic        o_scl_drive_low;
    logic        o_sda_drive_low;
    logic        o_byte_valid;
    logic [7:0]  o_byte_value;
    logic        o_byte_last;
    logic        o_done_res;
    logic [2:0]  o_ack_mask;
    logic        o_success;
    logic        o_busy_res;

    i2c_master_register_read u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_register_index (i_register_index),
        .i_byte_count     (i_byte_count),
        .i_probe_address  (i_probe_address),
        .i_sda_level      (i_sda_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_scl_drive_low  (o_scl_drive_low),
        .o_sda_drive_low  (o_sda_drive_low),
        .o_byte_valid     (o_byte_valid),
        .o_byte_value     (o_byte_value),
        .o_byte_last      (o_byte_last),
        .o_done_res       (o_done_res),
        .o_ack_mask       (o_ack_mask),
        .o_success        (o_success),
        .o_busy_res       (o_busy_res)
    );

    always #1 i_clk = ~i_clk;

    // sequencer model state
    t_step       seq_step;
    logic [15:0] phase_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shifter;
    logic [4:0]  bytes_left;
    logic [2:0]  ack_seen;
    logic [7:0]  held_reg;
    logic [6:0]  held_addr;
    logic        probe_on;
    t_wstage     wstage;
    logic [6:0]  cfg_dev;
    logic [15:0] cfg_phase;

    t_bus_res    expected_ticks [$];
    logic        drv_typed = 1'b0;
    t_bus_res    drv_want  = '0;
    int          burst_left = 0;
    int          n_items = 0, n_results = 0, n_bad = 0;
    int          n_done = 0, n_succ = 0, n_bytes = 0;
    int          quiet = 0;
    logic [31:0] rdy_cyc = '0;

    task automatic model_reset();
        seq_step   = ST_IDLE;
        phase_cnt  = '0;
        bit_cnt    = '0;
        shifter    = '0;
        bytes_left = '0;
        ack_seen   = '0;
        held_reg   = '0;
        held_addr  = '0;
        probe_on   = 1'b0;
        wstage     = WS_ADDR_WR;
        cfg_dev    = DEV_ADDR_RST;
        cfg_phase  = PHASE_TICKS_RST;
    endtask

    function automatic t_bus_res bus_tick(t_cmd cmd, logic [7:0] ridx, logic [4:0] cnt,
                                          logic [6:0] paddr, logic sda_in);
        t_bus_res    r;
        int unsigned pt;
        logic        last;
        logic [4:0]  n;
        t_step       st;
        r  = '0;
        pt = (cfg_phase == 16'd0) ? 1 : 32'(cfg_phase);
        if (seq_step == ST_IDLE && (cmd == CMD_READ || cmd == CMD_PROBE)) begin
            n = (cnt == 5'd0) ? 5'd1 : cnt;
            if (n > 5'(MAX_READ_BYTES_DEF)) n = 5'(MAX_READ_BYTES_DEF);
            probe_on   = (cmd == CMD_PROBE);
            held_addr  = probe_on ? paddr : cfg_dev;
            held_reg   = ridx;
            bytes_left = n;
            ack_seen   = '0;
            wstage     = WS_ADDR_WR;
            bit_cnt    = '0;
            shifter    = '0;
            phase_cnt  = '0;
            seq_step   = ST_START0;
        end
        if (seq_step != ST_IDLE) begin
            r.busy = 1'b1;
            st     = seq_step;
            last   = (32'(phase_cnt) + 32'd1) >= pt;
            case (st)
                ST_START1: r.sda_low = 1'b1;
                ST_START2: begin
                    r.scl_low = 1'b1;
                    r.sda_low = 1'b1;
                end
                ST_WBIT0, ST_WBIT1, ST_WBIT2: begin
                    r.scl_low = (st != ST_WBIT1);
                    r.sda_low = ~shifter[7];
                end
                ST_WACK0, ST_WACK2, ST_RBIT1: r.scl_low = 1'b1;
                ST_RACK0, ST_RACK1, ST_RACK2: begin
                    r.scl_low = (st != ST_RACK1);
                    r.sda_low = (bytes_left > 5'd1);
                end
                ST_STOP0: begin
                    r.scl_low = 1'b1;
                    r.sda_low = 1'b1;
                end
                ST_STOP1: r.sda_low = 1'b1;
                default: ;
            endcase
            if (!last) begin
                phase_cnt = phase_cnt + 16'd1;
            end else begin
                phase_cnt = '0;
                case (st)
                    ST_START2: begin
                        shifter  = {held_addr, wstage == WS_ADDR_RD};
                        bit_cnt  = '0;
                        seq_step = ST_WBIT0;
                    end
                    ST_WBIT2: begin
                        shifter  = {shifter[6:0], 1'b0};
                        bit_cnt  = bit_cnt + 4'd1;
                        seq_step = (bit_cnt >= 4'd8) ? ST_WACK0 : ST_WBIT0;
                    end
                    ST_WACK1: begin
                        if (!sda_in) begin
                            ack_seen = ack_seen | ((wstage == WS_ADDR_WR) ? ACK_ADDR_WR :
                                                   (wstage == WS_REG) ? ACK_REG : ACK_ADDR_RD);
                        end
                        seq_step = ST_WACK2;
                    end
                    ST_WACK2: begin
                        bit_cnt = '0;
                        if (wstage == WS_ADDR_WR && probe_on) begin
                            seq_step = ST_STOP0;
                        end else if (wstage == WS_ADDR_WR) begin
                            wstage   = WS_REG;
                            shifter  = held_reg;
                            seq_step = ST_WBIT0;
                        end else if (wstage == WS_REG) begin
                            wstage   = WS_ADDR_RD;
                            seq_step = ST_START0;
                        end else begin
                            shifter  = '0;
                            seq_step = ST_RBIT0;
                        end
                    end
                    ST_RBIT0: begin
                        shifter = {shifter[6:0], sda_in};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= 4'd8) begin
                            r.byte_vld = 1'b1;
                            r.byte_val = shifter;
                            r.byte_end = (bytes_left <= 5'd1);
                        end
                        seq_step = ST_RBIT1;
                    end
                    ST_RBIT1: seq_step = (bit_cnt >= 4'd8) ? ST_RACK0 : ST_RBIT0;
                    ST_RACK2: begin
                        if (bytes_left > 5'd0) bytes_left = bytes_left - 5'd1;
                        bit_cnt  = '0;
                        shifter  = '0;
                        seq_step = (bytes_left == 5'd0) ? ST_STOP0 : ST_RBIT0;
                    end
                    ST_STOP2: begin
                        r.done   = 1'b1;
                        r.ok     = probe_on ? ack_seen[0] : (ack_seen == ACK_ALL);
                        seq_step = ST_IDLE;
                    end
                    default: seq_step = (st < ST_STOP2) ? t_step'(st + 5'd1) : ST_IDLE;
                endcase
            end
        end
        r.acks = ack_seen;
        return r;
    endfunction

    function automatic string fmt_res(t_bus_res r);
        return $sformatf("scl=%b sda=%b bv=%b byte=%02h last=%b done=%b ack=%03b ok=%b busy=%b",
                         r.scl_low, r.sda_low, r.byte_vld, r.byte_val, r.byte_end,
                         r.done, r.acks, r.ok, r.busy);
    endfunction

    // scoreboard, config tracking and watchdog
    always @(posedge i_clk) begin
        t_bus_res got;
        t_bus_res want;
        string    bad;
        logic     moved;
        if (!i_rst_n) begin
            model_reset();
            expected_ticks.delete();
            quiet = 0;
        end else begin
            moved = 1'b0;
            got = '{scl_low: o_scl_drive_low, sda_low: o_sda_drive_low,
                    byte_vld: o_byte_valid, byte_val: o_byte_value, byte_end: o_byte_last,
                    done: o_done_res, acks: o_ack_mask, ok: o_success, busy: o_busy_res};
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_ticks.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("result %0d with nothing expected: %s",
                                              n_results, fmt_res(got));
                end else begin
                    want = expected_ticks.pop_front();
                    bad  = "";
                    if (got.scl_low  !== want.scl_low)  bad = {bad, " scl"};
                    if (got.sda_low  !== want.sda_low)  bad = {bad, " sda"};
                    if (got.byte_vld !== want.byte_vld) bad = {bad, " byte_valid"};
                    if (got.byte_val !== want.byte_val) bad = {bad, " byte_value"};
                    if (got.byte_end !== want.byte_end) bad = {bad, " byte_last"};
                    if (got.done     !== want.done)     bad = {bad, " done"};
                    if (got.acks     !== want.acks)     bad = {bad, " ack_mask"};
                    if (got.ok       !== want.ok)       bad = {bad, " success"};
                    if (got.busy     !== want.busy)     bad = {bad, " busy"};
                    if (bad != "") begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("result %0d differs in%s", n_results, bad);
                            $display("  expected %s", fmt_res(want));
                            $display("  actual   %s", fmt_res(got));
                        end
                    end
                end
                n_results++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEV_ADDR:    cfg_dev   = i_cfg_data[6:0];
                    CFG_PHASE_TICKS: cfg_phase = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                want = bus_tick(i_command, i_register_index, i_byte_count,
                                i_probe_address, i_sda_level);
                n_items++;
                if (want.done) n_done++;
                if (want.done && want.ok) n_succ++;
                if (want.byte_vld) n_bytes++;
                if (drv_typed) want = drv_want;
                expected_ticks.push_back(want);
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", quiet);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        rdy_cyc <= rdy_cyc + 32'd1;
        case (rdy_cyc[10:9])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: i_out_ready <= (rdy_cyc % 32'd7) < 32'd4;
            default: i_out_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // entered and left at a falling edge
    task automatic send_tick(input t_cmd cmd, input logic [7:0] ridx, input logic [4:0] cnt,
                             input logic [6:0] paddr, input logic sda, input logic typed,
                             input t_bus_res want);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 7)) begin
                    i_in_valid <= 1'b0;
                    @(negedge i_clk);
                end
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_register_index <= ridx;
        i_byte_count     <= cnt;
        i_probe_address  <= paddr;
        i_sda_level      <= sda;
        drv_typed        <= typed;
        drv_want         <= want;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    // run the bus back to idle and drain every result
    task automatic finish_transfer();
        while (seq_step != ST_IDLE) begin
            send_tick(CMD_NONE, 8'($urandom), 5'($urandom), 7'($urandom),
                      1'($urandom_range(0, 1)), 1'b0, RES_IDLE);
        end
        i_in_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        finish_transfer();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        t_cmd        cmd;
        logic [4:0]  cnt;
        logic        sda;
        logic [6:0]  dev;
        logic [15:0] ph;
        int          pick, sda_mode, items0;
        sda_mode = 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            if (DIRECTED[i].is_cfg) begin
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end else begin
                for (int k = 0; k < int'(DIRECTED[i].reps); k++) begin
                    sda = DIRECTED[i].sda_rand ? 1'($urandom_range(0, 1)) : DIRECTED[i].sda;
                    send_tick(DIRECTED[i].cmd, DIRECTED[i].ridx, DIRECTED[i].cnt,
                              DIRECTED[i].paddr, sda, DIRECTED[i].typed && k == 0,
                              DIRECTED[i].want);
                end
            end
        end

        for (int p = 0; p < N_SETTINGS; p++) begin
            case (p)
                0:       begin dev = 7'($urandom); ph = 16'd1; end
                default: begin dev = 7'h7f;        ph = 16'd2; end
            endcase
            write_reg(CFG_DEV_ADDR, {9'd0, dev});
            write_reg(CFG_PHASE_TICKS, ph);
            items0 = n_items;
            while (n_items - items0 < RAND_ITEMS) begin
                if (seq_step == ST_IDLE) begin
                    pick = $urandom_range(0, 99);
                    cmd  = (pick < 55) ? CMD_READ : (pick < 80) ? CMD_PROBE :
                           (pick < 88) ? CMD_RSVD : CMD_NONE;
                    pick = $urandom_range(0, 99);
                    sda_mode = (pick < 50) ? 0 : (pick < 85) ? 1 : 2;
                end else begin
                    cmd = ($urandom_range(0, 19) == 0) ? t_cmd'($urandom_range(0, 3))
                                                       : CMD_NONE;
                end
                pick = $urandom_range(0, 9);
                cnt  = (pick < 8) ? 5'($urandom_range(0, 2)) : 5'($urandom_range(3, 5));
                case (sda_mode)
                    0:       sda = ($urandom_range(0, 9) == 0);
                    1:       sda = 1'($urandom_range(0, 1));
                    default: sda = ($urandom_range(0, 9) != 0);
                endcase
                send_tick(cmd, 8'($urandom), cnt, 7'($urandom), sda, 1'b0, RES_IDLE);
            end
        end

        finish_transfer();
        repeat (8) @(negedge i_clk);
        $display("%0d bus ticks checked; %0d transfers finished, %0d acknowledged, %0d bytes read",
                 n_items, n_done, n_succ, n_bytes);
        $display("covered probes and reads at zero to two tick phases, clamped and zero counts");
        if (n_bad == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
